FILE: rtl/naue_pkg.sv
// shared types and constants of the node activity update engine
package naue_pkg;

   // storage geometry
   localparam int NODES       = 1024;
   localparam int NODE_W      = 10;
   localparam int ADDR_W      = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CMP_W       = ((ADDR_W > NODE_W) ? ADDR_W : NODE_W) + 1;
   localparam int QUEUE_DEPTH = 2;

   // field and register widths
   localparam int DATA_W  = 32;
   localparam int FUNC_W  = 2;
   localparam int INC_W   = 20;
   localparam int DECAY_W = 16;
   localparam int SIGN_W  = 2;
   localparam int DELTA_W = INC_W + 3;
   localparam int SUM_W   = DATA_W + 2;

   // decay arithmetic: Q23.8 times Q0.16 gives Q23.24
   localparam int PROD_W     = DATA_W + DECAY_W;
   localparam int FRAC_SHIFT = 24;
   localparam int SCALE_W    = DATA_W - (PROD_W - FRAC_SHIFT);
   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((64'd1 << FRAC_SHIFT) - 64'd1);

   localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(NODES - 1);
   localparam logic [NODE_W-1:0] LAST_TOUCHED = NODE_W'(NODES - 1);

   // operation codes on the request channel
   localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_EDGE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DECAY = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd3;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_START     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INCREMENT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECREMENT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGN      = 3'd6;

   // register reset values
   localparam logic signed [DATA_W-1:0]  RST_START = 32'sd256;
   localparam logic [INC_W-1:0]          RST_INC   = 20'd256;
   localparam logic [INC_W-1:0]          RST_DEC   = 20'd256;
   localparam logic signed [DATA_W-1:0]  RST_UPPER = 32'sd2560;
   localparam logic signed [DATA_W-1:0]  RST_LOWER = 32'sd0;
   localparam logic [DECAY_W-1:0]        RST_DECAY = 16'd62259;
   localparam logic signed [SIGN_W-1:0]  RST_SIGN  = 2'sd1;

   typedef enum logic [1:0] {
      OP_MARK,
      OP_EDGE,
      OP_DECAY,
      OP_INIT
   } op_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  start_value;
      logic [INC_W-1:0]          increment;
      logic [INC_W-1:0]          decrement;
      logic signed [DATA_W-1:0]  upper_limit;
      logic signed [DATA_W-1:0]  lower_limit;
      logic [DECAY_W-1:0]        decay_factor;
      logic signed [SIGN_W-1:0]  direction_sign;
   } cfg_type;

   // classified command handed from front to back
   typedef struct packed {
      op_type                    op;
      logic                      in_range;
      logic [ADDR_W-1:0]         addr;
      logic [NODE_W-1:0]         node;
      logic signed [DELTA_W-1:0] delta;
   } cmd_type;

endpackage

FILE: rtl/naue_ram.sv
// generic single write port, single read port ram with registered read
module naue_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/naue_front.sv
// front end: accepts requests, classifies them and queues commands
module naue_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [naue_pkg::FUNC_W-1:0]   req_func,
   input  logic [naue_pkg::NODE_W-1:0]   req_node,
   input  logic                          req_flipped_side,
   input  logic                          req_neighbour_side,
   input  naue_pkg::cfg_type             cfg,
   input  logic                          hold,
   input  logic                          pop,
   output logic                          cmd_valid,
   output naue_pkg::cmd_type             cmd
);

   localparam int PTR_W = (naue_pkg::QUEUE_DEPTH > 1) ? $clog2(naue_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(naue_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(naue_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(naue_pkg::QUEUE_DEPTH);

   naue_pkg::cmd_type q_ff [naue_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   naue_pkg::cmd_type                    new_cmd;
   logic [naue_pkg::CMP_W-1:0]           node_ext;
   logic signed [naue_pkg::DELTA_W-1:0]  term;
   logic signed [naue_pkg::DELTA_W-1:0]  sign_ext;
   logic                                 push;

   // a transfer is taken while the queue has room and no clearing pass runs
   assign req_stall = (count_ff == FULL_CNT) || hold;
   assign push      = req_valid && !req_stall;

   // classify the request
   always_comb begin
      node_ext = naue_pkg::CMP_W'(req_node);
      sign_ext = {{(naue_pkg::DELTA_W - naue_pkg::SIGN_W){cfg.direction_sign[naue_pkg::SIGN_W-1]}},
                  cfg.direction_sign};
      // equal sides add the increment, differing sides take off the decrement
      if (req_flipped_side == req_neighbour_side) begin
         term = $signed({{(naue_pkg::DELTA_W - naue_pkg::INC_W){1'b0}}, cfg.increment});
      end else begin
         term = -$signed({{(naue_pkg::DELTA_W - naue_pkg::INC_W){1'b0}}, cfg.decrement});
      end
      new_cmd.delta    = term * sign_ext;
      new_cmd.node     = req_node;
      new_cmd.addr     = node_ext[naue_pkg::ADDR_W-1:0];
      new_cmd.in_range = node_ext < naue_pkg::CMP_W'(naue_pkg::NODES);
      case (req_func)
         naue_pkg::FUNC_MARK:  new_cmd.op = naue_pkg::OP_MARK;
         naue_pkg::FUNC_EDGE:  new_cmd.op = naue_pkg::OP_EDGE;
         naue_pkg::FUNC_DECAY: new_cmd.op = naue_pkg::OP_DECAY;
         default:              new_cmd.op = naue_pkg::OP_INIT;
      endcase
   end

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmd_valid = count_ff != '0;
   assign cmd       = q_ff[rd_ptr_ff];

endmodule

FILE: rtl/naue_back.sv
// back end: executes queued commands on the activity store
module naue_back (
   input  logic                          clock,
   input  logic                          reset,
   input  naue_pkg::cfg_type             cfg,
   input  logic                          cmd_valid,
   input  naue_pkg::cmd_type             cmd,
   output logic                          pop,
   output logic                          clearing,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [naue_pkg::NODE_W-1:0]   rsp_touched_node,
   output logic signed [naue_pkg::DATA_W-1:0] rsp_new_activity
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MARK,
      S_EDGE,
      S_INIT,
      S_DECAY,
      S_DONE
   } state_type;

   state_type                            state_ff, state_in;
   naue_pkg::cmd_type                    cur_ff, cur_in;
   logic [naue_pkg::ADDR_W-1:0]          sweep_ff, sweep_in;
   logic                                 rd_run_ff, rd_run_in;
   logic                                 p1_vld_ff, p1_vld_in;
   logic [naue_pkg::ADDR_W-1:0]          p1_addr_ff, p1_addr_in;
   logic                                 p2_vld_ff, p2_vld_in;
   logic [naue_pkg::ADDR_W-1:0]          p2_addr_ff, p2_addr_in;
   logic signed [naue_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [naue_pkg::NODE_W-1:0]          res_node_ff, res_node_in;
   logic signed [naue_pkg::DATA_W-1:0]   res_value_ff, res_value_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [naue_pkg::NODE_W-1:0]          rsp_node_ff, rsp_node_in;
   logic signed [naue_pkg::DATA_W-1:0]   rsp_value_ff, rsp_value_in;

   logic                                 wr_en;
   logic [naue_pkg::ADDR_W-1:0]          wr_addr;
   logic [naue_pkg::DATA_W-1:0]          wr_data;
   logic                                 rd_en;
   logic [naue_pkg::ADDR_W-1:0]          rd_addr;
   logic [naue_pkg::DATA_W-1:0]          rd_data;

   logic                                 out_free;
   logic                                 out_load;
   logic signed [naue_pkg::SUM_W-1:0]    cur_ext, delta_ext, upper_ext, lower_ext;
   logic signed [naue_pkg::SUM_W-1:0]    edge_sum, clamp_hi, clamp_lo;
   logic signed [naue_pkg::DATA_W-1:0]   edge_value;
   logic signed [naue_pkg::DATA_W+naue_pkg::DECAY_W:0] mult_full;
   logic signed [naue_pkg::PROD_W-1:0]   round_sum;
   logic [naue_pkg::DATA_W-1:0]          decay_value;

   naue_ram #(
      .WIDTH (naue_pkg::DATA_W),
      .DEPTH (naue_pkg::NODES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // edge update: add the delta, clamp to the ceiling and then to the floor
   always_comb begin
      cur_ext   = {{(naue_pkg::SUM_W - naue_pkg::DATA_W){rd_data[naue_pkg::DATA_W-1]}}, rd_data};
      delta_ext = {{(naue_pkg::SUM_W - naue_pkg::DELTA_W){cur_ff.delta[naue_pkg::DELTA_W-1]}},
                   cur_ff.delta};
      upper_ext = {{(naue_pkg::SUM_W - naue_pkg::DATA_W){cfg.upper_limit[naue_pkg::DATA_W-1]}},
                   cfg.upper_limit};
      lower_ext = {{(naue_pkg::SUM_W - naue_pkg::DATA_W){cfg.lower_limit[naue_pkg::DATA_W-1]}},
                   cfg.lower_limit};
      edge_sum   = cur_ext + delta_ext;
      clamp_hi   = (edge_sum > upper_ext) ? upper_ext : edge_sum;
      clamp_lo   = (clamp_hi < lower_ext) ? lower_ext : clamp_hi;
      edge_value = clamp_lo[naue_pkg::DATA_W-1:0];
   end

   // decay: product registered, then rounded up to a whole number
   always_comb begin
      mult_full   = $signed(rd_data) * $signed({1'b0, cfg.decay_factor});
      round_sum   = prod_ff + naue_pkg::ROUND_BIAS;
      decay_value = {round_sum[naue_pkg::PROD_W-1:naue_pkg::FRAC_SHIFT],
                     {naue_pkg::SCALE_W{1'b0}}};
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      sweep_in     = sweep_ff;
      rd_run_in    = rd_run_ff;
      p1_vld_in    = 1'b0;
      p1_addr_in   = sweep_ff;
      p2_vld_in    = 1'b0;
      p2_addr_in   = p1_addr_ff;
      prod_in      = mult_full[naue_pkg::PROD_W-1:0];
      res_node_in  = res_node_ff;
      res_value_in = res_value_ff;
      rsp_node_in  = rsp_node_ff;
      rsp_value_in = rsp_value_ff;
      out_load     = 1'b0;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = sweep_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = sweep_ff;

      case (state_ff)
         // write zero to every entry after reset
         S_CLEAR: begin
            wr_en = 1'b1;
            if (sweep_ff == naue_pkg::LAST_ADDR) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         // take the next command, start the store read for an edge
         S_IDLE: begin
            if (cmd_valid) begin
               pop    = 1'b1;
               cur_in = cmd;
               case (cmd.op)
                  naue_pkg::OP_MARK: begin
                     state_in     = cmd.in_range ? S_MARK : S_DONE;
                     res_node_in  = cmd.node;
                     res_value_in = '0;
                  end
                  naue_pkg::OP_EDGE: begin
                     rd_en        = cmd.in_range;
                     rd_addr      = cmd.addr;
                     state_in     = cmd.in_range ? S_EDGE : S_DONE;
                     res_node_in  = cmd.node;
                     res_value_in = '0;
                  end
                  naue_pkg::OP_DECAY: begin
                     sweep_in  = '0;
                     rd_run_in = 1'b1;
                     state_in  = S_DECAY;
                  end
                  default: begin
                     sweep_in = '0;
                     state_in = S_INIT;
                  end
               endcase
            end
         end
         S_MARK: begin
            if (out_free) begin
               wr_en        = 1'b1;
               wr_addr      = cur_ff.addr;
               wr_data      = cfg.start_value;
               out_load     = 1'b1;
               rsp_node_in  = cur_ff.node;
               rsp_value_in = cfg.start_value;
               state_in     = S_IDLE;
            end
         end
         // read data is held until the result slot frees up
         S_EDGE: begin
            if (out_free) begin
               wr_en        = 1'b1;
               wr_addr      = cur_ff.addr;
               wr_data      = edge_value;
               out_load     = 1'b1;
               rsp_node_in  = cur_ff.node;
               rsp_value_in = edge_value;
               state_in     = S_IDLE;
            end
         end
         S_INIT: begin
            wr_en   = 1'b1;
            wr_data = cfg.start_value;
            if (sweep_ff == naue_pkg::LAST_ADDR) begin
               sweep_in     = '0;
               res_node_in  = naue_pkg::LAST_TOUCHED;
               res_value_in = cfg.start_value;
               state_in     = S_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         // read, multiply, round and write back, one entry a cycle
         S_DECAY: begin
            rd_en     = rd_run_ff;
            p1_vld_in = rd_run_ff;
            p2_vld_in = p1_vld_ff;
            if (rd_run_ff) begin
               if (sweep_ff == naue_pkg::LAST_ADDR) begin
                  sweep_in  = '0;
                  rd_run_in = 1'b0;
               end else begin
                  sweep_in = sweep_ff + 1'b1;
               end
            end
            if (p2_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = p2_addr_ff;
               wr_data = decay_value;
               if (p2_addr_ff == naue_pkg::LAST_ADDR) begin
                  res_node_in  = naue_pkg::LAST_TOUCHED;
                  res_value_in = decay_value;
                  state_in     = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_node_in  = res_node_ff;
               rsp_value_in = res_value_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         rd_run_ff    <= 1'b0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rd_run_ff    <= rd_run_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      p1_addr_ff   <= p1_addr_in;
      p2_addr_ff   <= p2_addr_in;
      prod_ff      <= prod_in;
      res_node_ff  <= res_node_in;
      res_value_ff <= res_value_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign clearing         = state_ff == S_CLEAR;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_touched_node = rsp_node_ff;
   assign rsp_new_activity = rsp_value_ff;

endmodule

FILE: rtl/node_activity_update_engine.sv
// top level: csr registers, front end, back end and checks
// commands: mark, edge (store read, then add/clamp/write back), decay (read, multiply,
//   round/write pipeline over the one store) and init; one command runs in the back end
//   at a time
// results: the result register loads once a command has left the queue through S_IDLE
//   and the result slot is free; a two-entry queue sits between, and commands waiting
//   in it add the time of those ahead
// reset: synchronous; csr registers take their defaults and a clearing pass writes
//   zero to all NODES (1024) store entries, req_stall high for those cycles; csr
//   writes are taken during it
module node_activity_update_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [naue_pkg::FUNC_W-1:0]           req_func,
   input  logic [naue_pkg::NODE_W-1:0]           req_node,
   input  logic                                  req_flipped_side,
   input  logic                                  req_neighbour_side,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [naue_pkg::NODE_W-1:0]           rsp_touched_node,
   output logic signed [naue_pkg::DATA_W-1:0]    rsp_new_activity,
   input  logic                                  csr_wr_en,
   input  logic [naue_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [naue_pkg::DATA_W-1:0]           csr_wr_data
);

   naue_pkg::cfg_type cfg_ff, cfg_in;
   naue_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              pop;
   logic              clearing;

   // csr write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            naue_pkg::CSR_START:     cfg_in.start_value    = csr_wr_data;
            naue_pkg::CSR_INCREMENT: cfg_in.increment      = csr_wr_data[naue_pkg::INC_W-1:0];
            naue_pkg::CSR_DECREMENT: cfg_in.decrement      = csr_wr_data[naue_pkg::INC_W-1:0];
            naue_pkg::CSR_UPPER:     cfg_in.upper_limit    = csr_wr_data;
            naue_pkg::CSR_LOWER:     cfg_in.lower_limit    = csr_wr_data;
            naue_pkg::CSR_DECAY:     cfg_in.decay_factor   = csr_wr_data[naue_pkg::DECAY_W-1:0];
            naue_pkg::CSR_SIGN:      cfg_in.direction_sign = csr_wr_data[naue_pkg::SIGN_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_value    <= naue_pkg::RST_START;
         cfg_ff.increment      <= naue_pkg::RST_INC;
         cfg_ff.decrement      <= naue_pkg::RST_DEC;
         cfg_ff.upper_limit    <= naue_pkg::RST_UPPER;
         cfg_ff.lower_limit    <= naue_pkg::RST_LOWER;
         cfg_ff.decay_factor   <= naue_pkg::RST_DECAY;
         cfg_ff.direction_sign <= naue_pkg::RST_SIGN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   naue_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_node           (req_node),
      .req_flipped_side   (req_flipped_side),
      .req_neighbour_side (req_neighbour_side),
      .cfg                (cfg_ff),
      .hold               (clearing),
      .pop                (pop),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd)
   );

   naue_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .pop              (pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_touched_node (rsp_touched_node),
      .rsp_new_activity (rsp_new_activity)
   );

   // back end only takes commands that the queue holds
   assert property (@(posedge clock) disable iff (reset) pop |-> cmd_valid)
      else $error("command taken from an empty queue");

   // each command keeps the back end busy: pop is never high twice in a row
   assert property (@(posedge clock) disable iff (reset) pop |=> !pop)
      else $error("back end took commands in consecutive cycles");

   // no result can appear while the store is being cleared
   assert property (@(posedge clock) disable iff (reset) $rose(rsp_valid) |-> !clearing)
      else $error("result produced during clearing pass");

endmodule
